[sv/psd_pkg.sv]
// psd_pkg: shared types, register codes and fixed-point constants of the
// path loss / signal dominance pipeline.
// No dependencies; imported by every module of the block.
package psd_pkg;

    localparam int TAG_W   = 24;
    localparam int COORD_W = 32;
    localparam int DB_W    = 32;
    localparam int UQ8_W   = 24;

    // configuration port
    localparam int CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANTENNA_X      = 4'd0,
        REG_ANTENNA_Y      = 4'd1,
        REG_ANTENNA_Z      = 4'd2,
        REG_REF_LEVEL      = 4'd3,
        REG_PATH_LOSS_EXP  = 4'd4,
        REG_LOGISTIC_MID   = 4'd5,
        REG_LOGISTIC_STEEP = 4'd6,
        REG_MEASURE_MODE   = 4'd7
    } cfg_reg_t;

    typedef enum logic {
        MODE_STRENGTH  = 1'b0,
        MODE_DOMINANCE = 1'b1
    } mode_t;

    // arithmetic constants
    localparam int          LOG_FRAC_BITS     = 24;
    localparam logic [31:0] TEN_LOG10_TWO_Q30 = 32'd3232284966;
    localparam logic [31:0] LN_TWO_Q32        = 32'd2977044472;
    localparam int          WHOLE_BITS        = 5;
    localparam int          TAYLOR_TERMS      = 12;
    localparam int          QUOT_BITS         = 17;

    // floor(2^32 / k) for the Taylor divisors
    localparam logic [32:0] RECIP_Q32 [1:TAYLOR_TERMS] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
        33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
    };

    // pipeline depths
    localparam int FRONT_DEPTH  = 5 + LOG_FRAC_BITS + 5;
    localparam int LOGI_DEPTH   = 2 + WHOLE_BITS + 3 * TAYLOR_TERMS + 1 + QUOT_BITS;
    localparam int PIPE_LATENCY = FRONT_DEPTH + LOGI_DEPTH + 1;

    // beat token that travels with the logistic datapath
    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic              dom;
        logic [DB_W-1:0]   sat;
    } psd_tok_t;

    // |a - b| of two signed words, exact in 32 bits
    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [32:0] nd;
        d  = {a[31], a} - {b[31], b};
        nd = -d;
        return d[32] ? nd[31:0] : d[31:0];
    endfunction

    // clamp a 34-bit signed value to the 32-bit range
    function automatic logic [31:0] sat32(input logic signed [33:0] s);
        if (s > 34'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (s < -34'sd2147483648)
            return 32'h8000_0000;
        else
            return s[31:0];
    endfunction

endpackage

[sv/psd_logistic.sv]
// psd_logistic: logistic back end, |Z| split by ln2, 12-term exp Taylor
// series, and a one-bit-per-stage divider. Depends on psd_pkg.
module psd_logistic
    import psd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  psd_tok_t                tok_in,
    input  logic signed [34:0]      diff,
    input  logic [UQ8_W-1:0]        steep,
    output logic                    done,
    output logic [TAG_W-1:0]        tag_out,
    output logic signed [DB_W-1:0]  measure
);

    localparam int LD = LOGI_DEPTH;
    localparam int TS = 3 * TAYLOR_TERMS;

    psd_tok_t tk_reg [0:LD-1];
    logic     up_reg [0:LD-1];
    logic     tl_reg [1:LD-1];

    logic [34:0] mg_reg;
    logic [58:0] arg;

    logic [35:0]           rem_reg [0:WHOLE_BITS];
    logic [WHOLE_BITS-1:0] wb_reg  [0:WHOLE_BITS];

    logic [31:0]           rt_reg [1:TS];
    logic [WHOLE_BITS-1:0] tw_reg [1:TS];
    logic [31:0]           rt_w   [0:TS];
    logic [WHOLE_BITS-1:0] tw_w   [0:TS];
    logic [32:0]           term_w [0:TAYLOR_TERMS];
    logic [32:0]           sum_w  [0:TAYLOR_TERMS];

    logic [49:0]          dr_reg [0:QUOT_BITS];
    logic [33:0]          dn_reg [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] dq_reg [0:QUOT_BITS];

    logic [32:0] ex;
    logic [33:0] den;
    logic [49:0] num;

    logic                   done_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [DB_W-1:0]        measure_reg;
    logic [DB_W-1:0]        measure_next;

    // token pipe, valid bits cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < LD; j++)
                tk_reg[j] <= '0;
        end
        else
        begin
            tk_reg[0] <= tok_in;
            for (int j = 1; j < LD; j++)
                tk_reg[j] <= tk_reg[j-1];
        end
    end

    // stage 0: magnitude and sign of S - mid, sign bit carried to the end
    always_ff @(posedge clk)
    begin
        mg_reg    <= diff[34] ? 35'(-diff) : 35'(diff);
        up_reg[0] <= !diff[34];
        for (int j = 1; j < LD; j++)
            up_reg[j] <= up_reg[j-1];
    end

    // stage 1: Z = steep * |diff|, tail detect at 16.0
    assign arg = 59'(mg_reg) * 59'(steep);

    always_ff @(posedge clk)
    begin
        tl_reg[1]  <= |arg[58:36];
        rem_reg[0] <= arg[35:0];
        wb_reg[0]  <= '0;
        for (int j = 2; j < LD; j++)
            tl_reg[j] <= tl_reg[j-1];
    end

    // whole multiples of ln2, one quotient bit a stage
    for (genvar t = 0; t < WHOLE_BITS; t++)
    begin : g_whole
        logic [35:0] cmp;
        logic        ge;
        assign cmp = 36'(LN_TWO_Q32) << (WHOLE_BITS - 1 - t);
        assign ge  = rem_reg[t] >= cmp;
        always_ff @(posedge clk)
        begin
            rem_reg[t+1] <= ge ? rem_reg[t] - cmp : rem_reg[t];
            wb_reg[t+1]  <= {wb_reg[t][WHOLE_BITS-2:0], ge};
        end
    end

    // remainder r and shift n ride along the Taylor stages
    assign rt_w[0] = rem_reg[WHOLE_BITS][31:0];
    assign tw_w[0] = wb_reg[WHOLE_BITS];

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= TS; k++)
        begin
            rt_reg[k] <= rt_w[k-1];
            tw_reg[k] <= tw_w[k-1];
        end
    end

    for (genvar k = 1; k <= TS; k++)
    begin : g_carry
        assign rt_w[k] = rt_reg[k];
        assign tw_w[k] = tw_reg[k];
    end

    assign term_w[0] = 33'h1_0000_0000;
    assign sum_w[0]  = 33'h1_0000_0000;

    // one series term in three stages: product, reciprocal, correction
    for (genvar i = 0; i < TAYLOR_TERMS; i++)
    begin : g_term
        logic [31:0] xa_reg;
        logic [32:0] sa_reg;
        logic [31:0] xb_reg;
        logic [31:0] qb_reg;
        logic [32:0] sb_reg;
        logic [32:0] tc_reg;
        logic [32:0] sc_reg;
        logic [64:0] pa;
        logic [64:0] pb;
        logic [35:0] rr;
        logic        adj;
        logic [32:0] q;

        assign pa  = 65'(term_w[i]) * 65'(rt_w[3*i]);
        assign pb  = 65'(xa_reg) * 65'(RECIP_Q32[i+1]);
        assign rr  = 36'(xb_reg) - 36'(qb_reg) * 36'(i + 1);
        assign adj = rr >= 36'(i + 1);
        assign q   = 33'(qb_reg) + 33'(adj);

        always_ff @(posedge clk)
        begin
            xa_reg <= pa[63:32];
            sa_reg <= sum_w[i];
            xb_reg <= xa_reg;
            qb_reg <= pb[63:32];
            sb_reg <= sa_reg;
            tc_reg <= q;
            sc_reg <= (i % 2 == 0) ? sb_reg - q : sb_reg + q;
        end

        assign term_w[i+1] = tc_reg;
        assign sum_w[i+1]  = sc_reg;
    end

    // exp(-Z) = sum >> n, rounded numerators for the final quotient
    assign ex  = sum_w[TAYLOR_TERMS] >> tw_w[TS];
    assign den = 34'h1_0000_0000 + 34'(ex);
    assign num = up_reg[LD-QUOT_BITS-2] ? 50'h1_0000_0000_0000 + 50'(den[33:1])
                                        : {1'b0, ex, 16'b0} + 50'(den[33:1]);

    always_ff @(posedge clk)
    begin
        dr_reg[0] <= num;
        dn_reg[0] <= den;
        dq_reg[0] <= '0;
    end

    // restoring divider, one quotient bit a stage
    for (genvar t = 0; t < QUOT_BITS; t++)
    begin : g_div
        logic [49:0] cmp;
        logic        ge;
        assign cmp = 50'(dn_reg[t]) << (QUOT_BITS - 1 - t);
        assign ge  = dr_reg[t] >= cmp;
        always_ff @(posedge clk)
        begin
            dr_reg[t+1] <= ge ? dr_reg[t] - cmp : dr_reg[t];
            dn_reg[t+1] <= dn_reg[t];
            dq_reg[t+1] <= {dq_reg[t][QUOT_BITS-2:0], ge};
        end
    end

    // result select: strength, tail, or quotient
    always_comb
    begin
        if (!tk_reg[LD-1].dom)
            measure_next = tk_reg[LD-1].sat;
        else if (tl_reg[LD-1])
            measure_next = up_reg[LD-1] ? 32'h0001_0000 : 32'h0000_0000;
        else
            measure_next = 32'(dq_reg[QUOT_BITS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= tk_reg[LD-1].valid;
    end

    always_ff @(posedge clk)
    begin
        tag_reg     <= tk_reg[LD-1].tag;
        measure_reg <= measure_next;
    end

    assign done    = done_reg;
    assign tag_out = tag_reg;
    assign measure = measure_reg;

endmodule

[sv/path_loss_signal_dominance.sv]
// path_loss_signal_dominance: top level; configuration registers and the
// distance / log2 / loss front end. Depends on psd_pkg and psd_logistic.
//
// Takes one point per clock whenever start is high (busy is always low) and
// returns its strength or dominance with a done strobe, in order. The
// pipeline depth comes from the 24 log2 squaring stages, the 36 Taylor
// stages and the 17-stage quotient divider. done is not held: the receiver
// must take every result in its cycle. Configuration writes are always
// ready and must be made only with the pipeline empty.
module path_loss_signal_dominance
    import psd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [TAG_W-1:0]            tile_tag,
    input  logic signed [COORD_W-1:0]   point_x,
    input  logic signed [COORD_W-1:0]   point_y,
    input  logic signed [COORD_W-1:0]   point_z,
    output logic                        done,
    output logic [TAG_W-1:0]            tag_out,
    output logic signed [DB_W-1:0]      measure,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [31:0]                 cfg_data
);

    localparam int FD = FRONT_DEPTH;

    // configuration registers
    logic [COORD_W-1:0] antenna_x_reg;
    logic [COORD_W-1:0] antenna_y_reg;
    logic [COORD_W-1:0] antenna_z_reg;
    logic [DB_W-1:0]    ref_level_reg;
    logic [UQ8_W-1:0]   path_loss_exp_reg;
    logic [DB_W-1:0]    logistic_mid_reg;
    logic [UQ8_W-1:0]   logistic_steep_reg;
    mode_t              measure_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            antenna_x_reg      <= '0;
            antenna_y_reg      <= '0;
            antenna_z_reg      <= '0;
            ref_level_reg      <= '0;
            path_loss_exp_reg  <= 24'd196608;
            logistic_mid_reg   <= '0;
            logistic_steep_reg <= 24'd65536;
            measure_mode_reg   <= MODE_STRENGTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ANTENNA_X:      antenna_x_reg      <= cfg_data;
                REG_ANTENNA_Y:      antenna_y_reg      <= cfg_data;
                REG_ANTENNA_Z:      antenna_z_reg      <= cfg_data;
                REG_REF_LEVEL:      ref_level_reg      <= cfg_data;
                REG_PATH_LOSS_EXP:  path_loss_exp_reg  <= cfg_data[UQ8_W-1:0];
                REG_LOGISTIC_MID:   logistic_mid_reg   <= cfg_data;
                REG_LOGISTIC_STEEP: logistic_steep_reg <= cfg_data[UQ8_W-1:0];
                REG_MEASURE_MODE:   measure_mode_reg   <= mode_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // valid bits and tags of the front end
    logic [FD-1:0]    fv_reg;
    logic [TAG_W-1:0] ftag_reg [0:FD-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else
            fv_reg <= {fv_reg[FD-2:0], start && !busy};
    end

    always_ff @(posedge clk)
    begin
        ftag_reg[0] <= tile_tag;
        for (int j = 1; j < FD; j++)
            ftag_reg[j] <= ftag_reg[j-1];
    end

    // stage 0: axis distances
    logic [31:0] dx_reg, dy_reg, dz_reg;

    always_ff @(posedge clk)
    begin
        dx_reg <= abs_diff(point_x, antenna_x_reg);
        dy_reg <= abs_diff(point_y, antenna_y_reg);
        dz_reg <= abs_diff(point_z, antenna_z_reg);
    end

    // stage 1: squares
    logic [63:0] sqx_reg, sqy_reg, sqz_reg;

    always_ff @(posedge clk)
    begin
        sqx_reg <= 64'(dx_reg) * 64'(dx_reg);
        sqy_reg <= 64'(dy_reg) * 64'(dy_reg);
        sqz_reg <= 64'(dz_reg) * 64'(dz_reg);
    end

    // stage 2: squared range
    logic [65:0] r_reg;

    always_ff @(posedge clk)
    begin
        r_reg <= 66'(sqx_reg) + 66'(sqy_reg) + 66'(sqz_reg);
    end

    // stage 3: leading one
    logic [6:0]  msb_q;
    logic [6:0]  q_reg;
    logic [65:0] r4_reg;
    logic        rz_reg;

    always_comb
    begin
        msb_q = '0;
        for (int b = 0; b < 66; b++)
            if (r_reg[b])
                msb_q = 7'(b);
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= msb_q;
        r4_reg <= r_reg;
        rz_reg <= (r_reg == '0);
    end

    // stage 4: normalize to Q1.31
    logic [65:0] shifted;

    always_comb
    begin
        if (q_reg >= 7'd31)
            shifted = r4_reg >> (q_reg - 7'd31);
        else
            shifted = r4_reg << (7'd31 - q_reg);
    end

    logic [31:0]              lm_reg [0:LOG_FRAC_BITS];
    logic [LOG_FRAC_BITS-1:0] lf_reg [0:LOG_FRAC_BITS];
    logic [6:0]               lq_reg [0:LOG_FRAC_BITS];
    logic                     lz_reg [0:LOG_FRAC_BITS];

    always_ff @(posedge clk)
    begin
        lm_reg[0] <= shifted[31:0];
        lf_reg[0] <= '0;
        lq_reg[0] <= q_reg;
        lz_reg[0] <= rz_reg;
    end

    // log2 fraction, one bit per squaring stage
    for (genvar j = 0; j < LOG_FRAC_BITS; j++)
    begin : g_log
        logic [63:0] sq;
        logic [32:0] m;
        assign sq = 64'(lm_reg[j]) * 64'(lm_reg[j]);
        assign m  = sq[63:31];
        always_ff @(posedge clk)
        begin
            lm_reg[j+1] <= m[32] ? m[32:1] : m[31:0];
            lf_reg[j+1] <= {lf_reg[j][LOG_FRAC_BITS-2:0], m[32]};
            lq_reg[j+1] <= lq_reg[j];
            lz_reg[j+1] <= lz_reg[j];
        end
    end

    // log2 of distance in Q.25, sign and magnitude
    logic signed [31:0] lg;
    logic [29:0]        mag_reg;
    logic               ng_reg [0:2];
    logic               zr_reg [0:2];

    assign lg = $signed({1'b0, lq_reg[LOG_FRAC_BITS], lf_reg[LOG_FRAC_BITS]})
              - 32'sd268435456;

    always_ff @(posedge clk)
    begin
        mag_reg   <= lg[31] ? 30'(-lg) : lg[29:0];
        ng_reg[0] <= lg[31];
        zr_reg[0] <= lz_reg[LOG_FRAC_BITS];
        for (int j = 1; j < 3; j++)
        begin
            ng_reg[j] <= ng_reg[j-1];
            zr_reg[j] <= zr_reg[j-1];
        end
    end

    // dB scale, rounded half up on the magnitude
    logic [62:0] tq_full;
    logic [31:0] tq_reg;

    assign tq_full = 63'(mag_reg) * 63'(TEN_LOG10_TWO_Q30) + 63'h2000_0000;

    always_ff @(posedge clk)
    begin
        tq_reg <= tq_full[61:30];
    end

    // times path loss exponent
    logic [56:0] ls_full;
    logic [30:0] loss_reg;

    assign ls_full = 57'(tq_reg) * 57'(path_loss_exp_reg) + 57'h100_0000;

    always_ff @(posedge clk)
    begin
        loss_reg <= ls_full[55:25];
    end

    // strength S = S0 - loss
    logic signed [33:0] refx;
    logic signed [33:0] lossx;
    logic signed [33:0] s_reg;

    assign refx  = $signed({{2{ref_level_reg[31]}}, ref_level_reg});
    assign lossx = $signed({3'b0, loss_reg});

    always_ff @(posedge clk)
    begin
        if (zr_reg[2])
            s_reg <= refx;
        else if (ng_reg[2])
            s_reg <= refx + lossx;
        else
            s_reg <= refx - lossx;
    end

    // clamped strength and offset from the logistic midpoint
    logic signed [34:0] diff_reg;
    logic [DB_W-1:0]    sat_reg;

    always_ff @(posedge clk)
    begin
        diff_reg <= $signed({s_reg[33], s_reg})
                  - $signed({{3{logistic_mid_reg[31]}}, logistic_mid_reg});
        sat_reg  <= sat32(s_reg);
    end

    psd_tok_t tok;

    assign tok.valid = fv_reg[FD-1];
    assign tok.tag   = ftag_reg[FD-1];
    assign tok.dom   = (measure_mode_reg == MODE_DOMINANCE);
    assign tok.sat   = sat_reg;

    psd_logistic u_logistic (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (tok),
        .diff    (diff_reg),
        .steep   (logistic_steep_reg),
        .done    (done),
        .tag_out (tag_out),
        .measure (measure)
    );

endmodule

[sv/psd_checker.sv]
// psd_checker: port-level timing checks of path_loss_signal_dominance,
// bound to the top level. Depends on psd_pkg.
module psd_checker
    import psd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_ready
);

    // every accepted beat comes out after the fixed latency
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("accepted beat produced no result");

    // no result without a beat accepted the latency earlier
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without matching input beat");

    // input and configuration sides never hold off
    a_never_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("block stalled a channel");

endmodule

bind path_loss_signal_dominance psd_checker u_psd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
);

[tb/tb_path_loss_signal_dominance.sv]
// tb_path_loss_signal_dominance: self-checking bench for the path loss / dominance pipeline.
// Depends on psd_pkg and path_loss_signal_dominance; predicts each result in the bench.
`timescale 1ns / 100ps

module tb_path_loss_signal_dominance;
    import psd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [23:0] tag;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    typedef struct packed {
        logic [23:0] tag;
        logic [31:0] meas;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [23:0] tile_tag = '0;
    logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
    logic done;
    logic [23:0] tag_out;
    logic signed [31:0] measure;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // bench copy of the register file
    logic signed [31:0] ant_x, ant_y, ant_z, s0_level, mid_level;
    logic [23:0] ple_q, steep_q;
    mode_t mode_q;

    point_t pending_points[$];
    result_t expected_results[$];
    int sent_count = 0, checked_count = 0, mismatch_count = 0, cycle_count = 0;
    int dom_count = 0;
    int send_idle_pct = 6;
    bit hold_sender = 0;

    path_loss_signal_dominance dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // signed loss in dB Q.16 from the three axis spans (Q.8)
    function automatic longint calc_loss(logic [32:0] gx, logic [32:0] gy, logic [32:0] gz);
        logic [67:0] r;
        logic [63:0] mant;
        logic [23:0] frac;
        int msb;
        longint lg;
        logic [63:0] mag, tq, ls;
        r = 68'(gx) * 68'(gx) + 68'(gy) * 68'(gy) + 68'(gz) * 68'(gz);
        frac = '0;
        if (r == 0)
            return 0;
        msb = 67;
        while (!r[msb])
            msb--;
        if (msb >= 31)
            mant = 64'(r >> (msb - 31));
        else
            mant = 64'(r << (31 - msb));
        mant &= 64'hFFFF_FFFF;
        for (int b = 0; b < 24; b++)
        begin
            mant = (mant * mant) >> 31;
            frac = {frac[22:0], 1'b0};
            if (mant >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                mant = mant >> 1;
            end
        end
        lg = (longint'(msb) <<< 24) + longint'(frac) - (longint'(16) <<< 24);
        mag = lg < 0 ? 64'(-lg) : 64'(lg);
        tq = (mag * 64'(TEN_LOG10_TWO_Q30) + (64'd1 << 29)) >> 30;
        ls = (tq * 64'(ple_q) + (64'd1 << 24)) >> 25;
        return lg < 0 ? -longint'(ls) : longint'(ls);
    endfunction

    // logistic of steep * diff in Q.16
    function automatic logic [31:0] calc_dominance(longint diff);
        bit upper;
        logic [63:0] mag, arg, whole, rest, sum, term, ex, den;
        upper = diff >= 0;
        mag = upper ? 64'(diff) : 64'(-diff);
        arg = mag * 64'(steep_q);
        if (arg >= (64'd16 << 32))
            return upper ? 32'd65536 : 32'd0;
        whole = arg / 64'(LN_TWO_Q32);
        rest = arg - whole * 64'(LN_TWO_Q32);
        sum = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * rest) >> 32) / 64'(k);
            if (k & 1)
                sum -= term;
            else
                sum += term;
        end
        ex = sum >> whole;
        den = (64'd1 << 32) + ex;
        if (upper)
            return 32'(((64'd1 << 48) + den / 2) / den);
        return 32'(((ex << 16) + den / 2) / den);
    endfunction

    function automatic logic [32:0] axis_span(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d < 0 ? 33'(-d) : 33'(d);
    endfunction

    function automatic result_t predict_measure(point_t p);
        result_t res;
        longint s;
        s = longint'(s0_level) - calc_loss(axis_span(p.x, ant_x), axis_span(p.y, ant_y),
                                          axis_span(p.z, ant_z));
        res.tag = p.tag;
        if (mode_q == MODE_DOMINANCE)
            res.meas = calc_dominance(s - longint'(mid_level));
        else if (s > 64'sd2147483647)
            res.meas = 32'h7FFF_FFFF;
        else if (s < -64'sd2147483648)
            res.meas = 32'h8000_0000;
        else
            res.meas = s[31:0];
        return res;
    endfunction

    // driver: one beat per accepted start
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sent_count <= sent_count + 1;
            if (pending_points.size() > 0 && !hold_sender
                && $urandom_range(99) >= send_idle_pct)
            begin
                point_t p;
                p = pending_points.pop_front();
                expected_results = {expected_results, predict_measure(p)};
                if (mode_q == MODE_DOMINANCE)
                    dom_count <= dom_count + 1;
                start <= 1'b1;
                tile_tag <= p.tag;
                point_x <= p.x;
                point_y <= p.y;
                point_z <= p.z;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each done beat with the oldest expectation
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result tag=%h measure=%h", tag_out, measure);
            end
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                checked_count <= checked_count + 1;
                if (e.tag !== tag_out || e.meas !== measure)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: tag exp %h got %h, measure exp %h got %h",
                                 e.tag, tag_out, e.meas, measure);
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_path_loss_signal_dominance: FAIL");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ANTENNA_X:      ant_x = val;
            REG_ANTENNA_Y:      ant_y = val;
            REG_ANTENNA_Z:      ant_z = val;
            REG_REF_LEVEL:      s0_level = val;
            REG_PATH_LOSS_EXP:  ple_q = val[23:0];
            REG_LOGISTIC_MID:   mid_level = val;
            REG_LOGISTIC_STEEP: steep_q = val[23:0];
            REG_MEASURE_MODE:   mode_q = mode_t'(val[0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);
    endtask

    task automatic set_all(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                           logic [31:0] s0, logic [31:0] ple, logic [31:0] mid,
                           logic [31:0] st, mode_t m);
        write_reg(REG_ANTENNA_X, ax);
        write_reg(REG_ANTENNA_Y, ay);
        write_reg(REG_ANTENNA_Z, az);
        write_reg(REG_REF_LEVEL, s0);
        write_reg(REG_PATH_LOSS_EXP, ple);
        write_reg(REG_LOGISTIC_MID, mid);
        write_reg(REG_LOGISTIC_STEEP, st);
        write_reg(REG_MEASURE_MODE, 32'(m));
    endtask

    // points spread around the antenna, with random full-range ones mixed in
    task automatic queue_points(int n, int spread);
        point_t p;
        for (int i = 0; i < n; i++)
        begin
            p.tag = $urandom;
            if ($urandom_range(9) == 0)
            begin
                p.x = $urandom;
                p.y = $urandom;
                p.z = $urandom;
            end
            else
            begin
                p.x = ant_x + $urandom_range(2 * spread) - spread;
                p.y = ant_y + $urandom_range(2 * spread) - spread;
                p.z = ant_z + $urandom_range(2 * spread) - spread;
            end
            pending_points = {pending_points, p};
        end
    endtask

    task automatic queue_one(logic [23:0] t, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_t p;
        p = '{t, x, y, z};
        pending_points = {pending_points, p};
    endtask

    initial
    begin
        ant_x = 0; ant_y = 0; ant_z = 0; s0_level = 0; mid_level = 0;
        ple_q = 24'd196608; steep_q = 24'd65536; mode_q = MODE_STRENGTH;
        hold_sender = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        hold_sender = 0;

        // directed: reset values, zero distance, sub-metre, extremes
        queue_one(24'h000000, 0, 0, 0);
        queue_one(24'hFFFFFF, 32'h100, 0, 0);
        queue_one(24'h5A5A5A, 32'h80, 32'h40, 0);
        queue_one(24'hA5A5A5, 32'h1, 0, 0);
        queue_one(24'h123456, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        queue_one(24'h654321, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_one(24'h0F0F0F, 32'h7FFFFFFF, 32'h80000000, 32'h0);
        drain();

        // extreme antenna and levels, strength saturates high and low
        set_all(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'hFFFFFF, 0, 0, MODE_STRENGTH);
        queue_one(24'h111111, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        queue_one(24'h222222, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        queue_one(24'h333333, 32'h80000001, 32'h7FFFFFFF, 32'h80000000);
        drain();
        set_all(0, 0, 0, 32'h80000000, 32'hFFFFFF, 0, 0, MODE_STRENGTH);
        queue_one(24'h444444, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        queue_one(24'h555555, 32'h10, 0, 0);
        drain();

        // dominance: zero steepness, tails, max steepness
        set_all(0, 0, 0, 32'd0, 32'd196608, 32'h80000000, 0, MODE_DOMINANCE);
        queue_one(24'h666666, 32'h1000, 0, 0);
        drain();
        write_reg(REG_LOGISTIC_STEEP, 32'hFFFFFF);
        queue_one(24'h777777, 32'h1000, 0, 0);
        drain();
        write_reg(REG_LOGISTIC_MID, 32'h7FFFFFFF);
        drain();
        write_reg(REG_LOGISTIC_MID, 32'h7FFFFFFF);
        queue_one(24'h888888, 32'h1000, 0, 0);
        drain();
        write_reg(cfg_reg_t'(4'd9), 32'hDEADBEEF);
        write_reg(REG_LOGISTIC_MID, 0);
        write_reg(REG_LOGISTIC_STEEP, 32'hFF010000);
        queue_one(24'h999999, 0, 0, 0);
        queue_one(24'hAAAAAA, 32'h100, 0, 0);
        drain();

        // random phases over several settings and idle patterns
        for (int ph = 0; ph < 12; ph++)
        begin
            send_idle_pct = ph < 4 ? 6 : (ph < 8 ? 62 : 0);
            set_all($urandom_range(200000) - 100000, $urandom_range(200000) - 100000,
                    $urandom_range(20000), ($urandom_range(200) - 150) << 16,
                    $urandom_range(ph == 11 ? 24'hFFFFFF : 24'h60000),
                    ($urandom_range(200) - 150) << 16,
                    $urandom_range(ph == 10 ? 24'hFFFFFF : 24'h40000),
                    mode_t'(ph & 1));
            queue_points(70, ph % 3 == 0 ? 600 : 40000);
            // sender holds off until the pipeline is empty
            wait (pending_points.size() < 35);
            hold_sender = 1;
            while (expected_results.size() > 0)
                @(posedge clk);
            hold_sender = 0;
            queue_points(70, 5000);
            drain();
        end

        $display("checked %0d results of %0d points, %0d in dominance mode, 12 random phases",
                 checked_count, sent_count, dom_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb_path_loss_signal_dominance: PASS");
        else
            $display("tb_path_loss_signal_dominance: FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/psd_pkg.sv
sv/psd_logistic.sv
sv/path_loss_signal_dominance.sv
sv/psd_checker.sv
tb/tb_path_loss_signal_dominance.sv
